@@ src/mep_pkg.sv @@
package mep_pkg;

  // fixed point and index widths
  localparam int FRAC_BITS  = 27;
  localparam int PIXEL_BITS = 8;

  localparam int PIX_IN_W  = 8;
  localparam int PIX_USE_W = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;

  localparam int ORIGIN_W    = 32;
  localparam int STEP_W      = 31;
  localparam int ITER_W      = 8;
  localparam int BOUND_W     = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // pixel * step, then origin + product
  localparam int PROD_W = PIX_USE_W + STEP_W;
  localparam int C_W    = ((PROD_W + 1 > ORIGIN_W) ? PROD_W + 1 : ORIGIN_W) + 1;

  // magnitudes below 4.0, squares below 16.0, doubled cross term below 32.0
  localparam int MAG_W = FRAC_BITS + 2;
  localparam int SQ_W  = FRAC_BITS + 4;
  localparam int XY_W  = FRAC_BITS + 5;
  localparam int SUM_W = FRAC_BITS + 5;
  localparam int Z_W   = ((C_W > XY_W + 1) ? C_W : XY_W + 1) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [ORIGIN_W-1:0] X_ORIGIN_RST = ORIGIN_W'(-308700774);
  localparam logic [ORIGIN_W-1:0] Y_ORIGIN_RST = ORIGIN_W'(-201326592);
  localparam logic [STEP_W-1:0]   X_STEP_RST   = STEP_W'(3074732);
  localparam logic [STEP_W-1:0]   Y_STEP_RST   = STEP_W'(2396745);
  localparam logic [ITER_W-1:0]   MAX_ITER_RST = ITER_W'(20);
  localparam logic [BOUND_W-1:0]  BOUND_RST    = BOUND_W'(10);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_X_ORIGIN = 3'd0,
    CFG_Y_ORIGIN = 3'd1,
    CFG_X_STEP   = 3'd2,
    CFG_Y_STEP   = 3'd3,
    CFG_MAX_ITER = 3'd4,
    CFG_BOUND    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [ORIGIN_W-1:0] x_origin;
    logic [ORIGIN_W-1:0] y_origin;
    logic [STEP_W-1:0]   x_step;
    logic [STEP_W-1:0]   y_step;
    logic [ITER_W-1:0]   max_iterations;
    logic [BOUND_W-1:0]  escape_bound;
  } cfg_t;

  // queued point, two's complement; trivial means zero iterations
  typedef struct packed {
    logic [C_W-1:0] cx;
    logic [C_W-1:0] cy;
    logic           trivial;
  } point_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_DONE
  } back_state_t;

endpackage

@@ src/mep_front.sv @@
module mep_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [mep_pkg::PIX_IN_W-1:0]      pixel_x,
  input  logic [mep_pkg::PIX_IN_W-1:0]      pixel_y,
  input  mep_pkg::cfg_t                     cfg,
  input  logic                              queue_full,
  output logic                              push,
  output mep_pkg::point_t                   push_point
);
  import mep_pkg::*;

  logic              f_valid;
  logic              accept;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [C_W-1:0]    org_x;
  logic [C_W-1:0]    org_y;

  // one holding stage; stalls only when it cannot hand on to the queue
  assign push        = f_valid && !queue_full;
  assign pixel_stall = f_valid && queue_full;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  // pixel times step, registered
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_x <= PROD_W'(pixel_x[PIX_USE_W-1:0]) * PROD_W'(cfg.x_step);
      prod_y <= PROD_W'(pixel_y[PIX_USE_W-1:0]) * PROD_W'(cfg.y_step);
    end
  end

  // origin plus offset, exact
  assign org_x = {{(C_W-ORIGIN_W){cfg.x_origin[ORIGIN_W-1]}}, cfg.x_origin};
  assign org_y = {{(C_W-ORIGIN_W){cfg.y_origin[ORIGIN_W-1]}}, cfg.y_origin};

  assign push_point.cx      = org_x + {{(C_W-PROD_W){1'b0}}, prod_x};
  assign push_point.cy      = org_y + {{(C_W-PROD_W){1'b0}}, prod_y};
  // no iterations possible with a zero limit or a zero bound
  assign push_point.trivial = (cfg.max_iterations == '0) || (cfg.escape_bound == '0);

endmodule

@@ src/mep_queue.sv @@
module mep_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mep_pkg::point_t push_point,
  output logic            full,
  input  logic            pop,
  output mep_pkg::point_t head,
  output logic            empty
);
  import mep_pkg::*;

  point_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_point;
    end
  end

endmodule

@@ src/mep_back.sv @@
module mep_back (
  input  logic                       clk,
  input  logic                       rst,
  input  mep_pkg::cfg_t              cfg,
  input  mep_pkg::point_t            head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [mep_pkg::ITER_W-1:0] iteration_count,
  output logic                       draw_pixel
);
  import mep_pkg::*;

  localparam logic [Z_W-1:0] FOUR = Z_W'(4) << FRAC_BITS;

  back_state_t         state;
  back_state_t         state_next;

  logic [C_W-1:0]      cx;
  logic [C_W-1:0]      cy;
  logic [Z_W-1:0]      zx;
  logic [Z_W-1:0]      zy;
  logic [ITER_W-1:0]   k;
  logic [SQ_W-1:0]     sx;
  logic [SQ_W-1:0]     sy;
  logic [XY_W-1:0]     pxy;
  logic                cross_neg;

  logic [Z_W-1:0]      ax;
  logic [Z_W-1:0]      ay;
  logic [MAG_W-1:0]    mx;
  logic [MAG_W-1:0]    my;
  logic [2*MAG_W-1:0]  mul_xx;
  logic [2*MAG_W-1:0]  mul_yy;
  logic [2*MAG_W-1:0]  mul_xy;
  logic                sq_stop;
  logic [SUM_W-1:0]    mag_sum;
  logic [SUM_W-1:0]    bound;
  logic                bound_stop;
  logic [Z_W-1:0]      cross_term;
  logic [Z_W-1:0]      zx_new;
  logic [Z_W-1:0]      zy_new;
  logic                slot_free;
  logic                load;

  // square step: magnitudes, exit on limit or |x|,|y| >= 4, products
  assign ax      = zx[Z_W-1] ? -zx : zx;
  assign ay      = zy[Z_W-1] ? -zy : zy;
  assign mx      = ax[MAG_W-1:0];
  assign my      = ay[MAG_W-1:0];
  assign sq_stop = (k >= cfg.max_iterations) || (ax >= FOUR) || (ay >= FOUR);
  assign mul_xx  = (2*MAG_W)'(mx) * (2*MAG_W)'(mx);
  assign mul_yy  = (2*MAG_W)'(my) * (2*MAG_W)'(my);
  assign mul_xy  = (2*MAG_W)'(mx) * (2*MAG_W)'(my);

  // update step: bound test and new z
  assign mag_sum    = SUM_W'(sx) + SUM_W'(sy);
  assign bound      = SUM_W'({cfg.escape_bound, {FRAC_BITS{1'b0}}});
  assign bound_stop = (mag_sum >= bound);
  assign cross_term = cross_neg ? -Z_W'(pxy) : Z_W'(pxy);
  assign zx_new     = Z_W'(sx) - Z_W'(sy) + {{(Z_W-C_W){cx[C_W-1]}}, cx};
  assign zy_new     = cross_term + {{(Z_W-C_W){cy[C_W-1]}}, cy};

  assign slot_free = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          state_next = head.trivial ? ST_DONE : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        state_next = sq_stop ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = bound_stop ? ST_DONE : ST_SQUARE;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      ST_IDLE:   pop  = !empty;
      ST_SQUARE: ;
      ST_UPDATE: ;
      ST_DONE:   load = slot_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cx <= head.cx;
      cy <= head.cy;
      zx <= '0;
      zy <= '0;
      k  <= '0;
    end
    if (state == ST_SQUARE) begin
      sx        <= mul_xx[FRAC_BITS+SQ_W-1:FRAC_BITS];
      sy        <= mul_yy[FRAC_BITS+SQ_W-1:FRAC_BITS];
      pxy       <= mul_xy[FRAC_BITS-1+XY_W-1:FRAC_BITS-1];
      cross_neg <= zx[Z_W-1] ^ zy[Z_W-1];
    end
    if (state == ST_UPDATE && !bound_stop) begin
      k  <= k + 1'b1;
      zx <= zx_new;
      zy <= zy_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      iteration_count <= k;
      draw_pixel      <= ~k[0];
    end
  end

endmodule

@@ src/mandelbrot_escape_pixel_top.sv @@
// channel   handshake                   payload
// pixel     pixel_valid / pixel_stall   pixel_x, pixel_y
// result    result_valid / result_stall iteration_count, draw_pixel
// config    cfg_write                   cfg_index, cfg_data
//
// The iteration unit loads an item, runs each iteration as a multiply
// step then an add and bound test step, exits from either step and
// presents the result; a zero limit or bound goes from load straight
// to the result. That unit sets the rate. The front stage and a two-entry
// queue take up to three further items while a result waits; reset (rst,
// synchronous) empties them and restores the register defaults.
module mandelbrot_escape_pixel_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  logic [mep_pkg::PIX_IN_W-1:0]   pixel_x,
  input  logic [mep_pkg::PIX_IN_W-1:0]   pixel_y,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [mep_pkg::ITER_W-1:0]     iteration_count,
  output logic                           draw_pixel,
  input  logic                           cfg_write,
  input  logic [mep_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mep_pkg::*;

  cfg_t   cfg;
  logic   queue_full;
  logic   queue_empty;
  logic   push;
  logic   pop;
  point_t push_point;
  point_t head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin       <= X_ORIGIN_RST;
      cfg.y_origin       <= Y_ORIGIN_RST;
      cfg.x_step         <= X_STEP_RST;
      cfg.y_step         <= Y_STEP_RST;
      cfg.max_iterations <= MAX_ITER_RST;
      cfg.escape_bound   <= BOUND_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_X_ORIGIN: cfg.x_origin       <= cfg_data[ORIGIN_W-1:0];
        CFG_Y_ORIGIN: cfg.y_origin       <= cfg_data[ORIGIN_W-1:0];
        CFG_X_STEP:   cfg.x_step         <= cfg_data[STEP_W-1:0];
        CFG_Y_STEP:   cfg.y_step         <= cfg_data[STEP_W-1:0];
        CFG_MAX_ITER: cfg.max_iterations <= cfg_data[ITER_W-1:0];
        CFG_BOUND:    cfg.escape_bound   <= cfg_data[BOUND_W-1:0];
        default:      ;
      endcase
    end
  end

  mep_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .cfg         (cfg),
    .queue_full  (queue_full),
    .push        (push),
    .push_point  (push_point)
  );

  mep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_point (push_point),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty)
  );

  mep_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head            (head),
    .empty           (queue_empty),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .iteration_count (iteration_count),
    .draw_pixel      (draw_pixel)
  );

endmodule

@@ src/mep_checker.sv @@
module mep_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pixel_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [mep_pkg::ITER_W-1:0] iteration_count,
  input logic                       draw_pixel
);

  // a stalled result stays offered and unchanged
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(iteration_count) && $stable(draw_pixel))
    else $error("stalled result changed");

  // draw flag marks an even count
  a_draw_even: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (draw_pixel == ~iteration_count[0]))
    else $error("draw flag does not match count parity");

  // reset empties the result register
  a_reset_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered after reset");

  // reset empties the front stage, so input is taken at once
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !pixel_stall)
    else $error("input stalled after reset");

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_checker (.*);

@@ sim/mandelbrot_escape_pixel_top_tb.sv @@
`timescale 1ns / 100ps

module mandelbrot_escape_pixel_top_tb;
  import mep_pkg::*;

  localparam int IDLE_PCT   = 23;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 600;
  localparam int ONE = 1 << FRAC_BITS;

  typedef struct packed {
    logic [ITER_W-1:0] count;
    logic              draw;
  } escape_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_stall;
  logic [PIX_IN_W-1:0]    pixel_x = '0;
  logic [PIX_IN_W-1:0]    pixel_y = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [ITER_W-1:0]      iteration_count;
  logic                   draw_pixel;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_X_ORIGIN;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of the registers
  cfg_t view_cfg = '{x_origin: X_ORIGIN_RST, y_origin: Y_ORIGIN_RST,
                     x_step: X_STEP_RST, y_step: Y_STEP_RST,
                     max_iterations: MAX_ITER_RST, escape_bound: BOUND_RST};

  escape_result_t expected_results[$];
  int             errors = 0;
  logic           quiet = 1'b0;    // no idling on either side
  logic           holding = 1'b0;  // receiver holds off
  event           hold_results;

  mandelbrot_escape_pixel_top dut (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .iteration_count (iteration_count),
    .draw_pixel      (draw_pixel),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // escape-time count for one pixel under the current view
  function automatic escape_result_t predict_escape(input logic [PIX_IN_W-1:0] px,
                                                    input logic [PIX_IN_W-1:0] py);
    escape_result_t    res;
    longint            pmask, cx, cy, zx, zy, cross_val;
    longint unsigned   ax, ay, sx, sy, pxy, four, bound;
    int unsigned       k;
    pmask = (longint'(1) << PIXEL_BITS) - 1;
    cx = longint'($signed(view_cfg.x_origin))
         + (longint'(px) & pmask) * longint'(view_cfg.x_step);
    cy = longint'($signed(view_cfg.y_origin))
         + (longint'(py) & pmask) * longint'(view_cfg.y_step);
    four  = 64'd4 << FRAC_BITS;
    bound = 64'(view_cfg.escape_bound) << FRAC_BITS;
    zx = 0;
    zy = 0;
    k = 0;
    while (k < int'(view_cfg.max_iterations)) begin
      ax = (zx < 0) ? -zx : zx;
      ay = (zy < 0) ? -zy : zy;
      // |x| or |y| of 4.0 or more saturates the magnitude and always escapes
      if (ax >= four || ay >= four) break;
      sx = (ax * ax) >> FRAC_BITS;
      sy = (ay * ay) >> FRAC_BITS;
      if (sx + sy >= bound) break;
      k++;
      // doubled cross term on magnitudes, sign applied afterwards
      pxy = (ax * ay) >> (FRAC_BITS - 1);
      cross_val = ((zx < 0) != (zy < 0)) ? -longint'(pxy) : longint'(pxy);
      zx = longint'(sx) - longint'(sy) + cx;
      zy = cross_val + cy;
    end
    res.count = k[ITER_W-1:0];
    res.draw  = ~k[0];
    return res;
  endfunction

  // offer one pixel, with random idling ahead of it
  task automatic send_pixel(input logic [PIX_IN_W-1:0] x, input logic [PIX_IN_W-1:0] y);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_x     <= x;
    pixel_y     <= y;
    do @(posedge clk); while (pixel_stall);
    expected_results.push_back(predict_escape(x, y));
  endtask

  // stop offering and wait for every outstanding result
  task automatic finish_batch();
    pixel_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_X_ORIGIN: view_cfg.x_origin       = data;
      CFG_Y_ORIGIN: view_cfg.y_origin       = data;
      CFG_X_STEP:   view_cfg.x_step         = data[STEP_W-1:0];
      CFG_Y_STEP:   view_cfg.y_step         = data[STEP_W-1:0];
      CFG_MAX_ITER: view_cfg.max_iterations = data[ITER_W-1:0];
      CFG_BOUND:    view_cfg.escape_bound   = data[BOUND_W-1:0];
      default: ;
    endcase
  endtask

  // load a whole view once idle; unused upper data bits carry noise
  task automatic set_view(input logic [ORIGIN_W-1:0] xo, input logic [ORIGIN_W-1:0] yo,
                          input logic [STEP_W-1:0] xs, input logic [STEP_W-1:0] ys,
                          input logic [ITER_W-1:0] mi, input logic [BOUND_W-1:0] eb);
    finish_batch();
    write_reg(CFG_X_ORIGIN, xo);
    write_reg(CFG_Y_ORIGIN, yo);
    write_reg(CFG_X_STEP, {1'($urandom), xs});
    write_reg(CFG_Y_STEP, {1'($urandom), ys});
    write_reg(CFG_MAX_ITER, {24'($urandom), mi});
    write_reg(CFG_BOUND, {28'($urandom), eb});
    cfg_write <= 1'b0;
  endtask

  // result side: check each accepted item, then pick the next stall
  always @(posedge clk) begin : result_check
    escape_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: iteration_count %0d draw_pixel %0d",
                 iteration_count, draw_pixel);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (iteration_count !== want.count) begin
            $error("iteration_count: expected %0d, got %0d", want.count, iteration_count);
            errors++;
          end
          if (draw_pixel !== want.draw) begin
            $error("draw_pixel: expected %0d, got %0d", want.draw, draw_pixel);
            errors++;
          end
        end
      end
      result_stall <= holding || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // long receiver hold-off, counted here
  always @(hold_results) begin
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // reset view: corners, a point inside the set, alternating bits
  task automatic test_default_view();
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd100, 8'd84);
    send_pixel(8'hAA, 8'h55);
    send_pixel(8'h55, 8'hAA);
    send_pixel(8'd1, 8'd1);
  endtask

  // no iterations allowed: count 0 everywhere; steps at zero
  task automatic test_zero_limit();
    set_view(X_ORIGIN_RST, Y_ORIGIN_RST, '0, '0, '0, BOUND_RST);
    send_pixel(8'd100, 8'd84);
    send_pixel(8'd255, 8'd0);
  endtask

  // zero bound ends at once
  task automatic test_zero_bound();
    set_view(X_ORIGIN_RST, Y_ORIGIN_RST, X_STEP_RST, Y_STEP_RST, MAX_ITER_RST, '0);
    send_pixel(8'd100, 8'd84);
    send_pixel(8'd0, 8'd0);
  endtask

  // full limit and widest bound, points inside and near the set
  task automatic test_deep_orbits();
    set_view(X_ORIGIN_RST, Y_ORIGIN_RST, X_STEP_RST, Y_STEP_RST, '1, '1);
    send_pixel(8'd100, 8'd84);
    send_pixel(8'd110, 8'd84);
    send_pixel(8'd60, 8'd100);
  endtask

  // extreme origins and steps: the magnitude saturates after one iteration
  task automatic test_far_points();
    set_view(32'h8000_0000, 32'h7FFF_FFFF, '1, '1, '1, '1);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
  endtask

  // smallest non-zero bound
  task automatic test_unit_bound();
    set_view(X_ORIGIN_RST, Y_ORIGIN_RST, X_STEP_RST, Y_STEP_RST, MAX_ITER_RST, 4'd1);
    send_pixel(8'd100, 8'd84);
    send_pixel(8'd37, 8'd200);
  endtask

  // random windows, mostly around the set, some anywhere
  task automatic test_random_views(input int phases, input int per_phase, input bit deep);
    logic [ORIGIN_W-1:0] xo, yo;
    logic [STEP_W-1:0]   xs, ys;
    logic [ITER_W-1:0]   mi;
    logic [BOUND_W-1:0]  eb;
    for (int p = 0; p < phases; p++) begin
      if (deep) begin
        xo = $urandom_range(0, ONE) - 2 * ONE;
        yo = $urandom_range(0, ONE) - ONE;
        xs = STEP_W'($urandom_range(ONE / 2048, ONE / 256));
        ys = STEP_W'($urandom_range(ONE / 2048, ONE / 256));
        mi = ITER_W'($urandom_range(150, 255));
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          xo = $urandom;
          yo = $urandom;
        end else begin
          xo = $urandom_range(0, 7 * ONE / 2) - 5 * ONE / 2;
          yo = $urandom_range(0, 3 * ONE) - 3 * ONE / 2;
        end
        xs = ($urandom_range(0, 9) == 0) ? STEP_W'($urandom)
                                          : STEP_W'($urandom_range(0, ONE / 32));
        ys = ($urandom_range(0, 9) == 0) ? STEP_W'($urandom)
                                          : STEP_W'($urandom_range(0, ONE / 32));
        mi = ($urandom_range(0, 15) == 0) ? '0 : ITER_W'($urandom_range(1, 40));
      end
      eb = ($urandom_range(0, 19) == 0) ? '0 : BOUND_W'($urandom_range(1, 15));
      set_view(xo, yo, xs, ys, mi, eb);
      quiet <= (!deep && p == 3);
      repeat (per_phase) send_pixel(PIX_IN_W'($urandom), PIX_IN_W'($urandom));
    end
  endtask

  // results held off while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    set_view(X_ORIGIN_RST, Y_ORIGIN_RST, X_STEP_RST, Y_STEP_RST, 8'd16, BOUND_RST);
    quiet <= 1'b1;
    -> hold_results;
    repeat (24) send_pixel(PIX_IN_W'($urandom), PIX_IN_W'($urandom));
    quiet <= 1'b0;
    finish_batch();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_default_view();
    test_zero_limit();
    test_zero_bound();
    test_deep_orbits();
    test_far_points();
    test_unit_bound();
    test_random_views(10, 120, 1'b0);
    test_random_views(1, 30, 1'b1);
    test_backpressure();
    finish_batch();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("mandelbrot_escape_pixel_top: match");
    end else begin
      $display("mandelbrot_escape_pixel_top: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("mandelbrot_escape_pixel_top: mismatch");
    $finish;
  end

endmodule

@@ mandelbrot_escape_pixel_top.f @@
src/mep_pkg.sv
src/mep_front.sv
src/mep_queue.sv
src/mep_back.sv
src/mandelbrot_escape_pixel_top.sv
src/mep_checker.sv
sim/mandelbrot_escape_pixel_top_tb.sv
